/* rtl/pndc_pkg.sv */
`timescale 1ns / 1ps
package pndc_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC      = 16;
    localparam int SQ_STEPS  = 34;

    localparam longint unsigned ONE_Q = 64'd1 << FRAC;

    localparam logic [17:0] HEAT_OFFSET = 18'((22 * ONE_Q + 50) / 100);
    localparam logic [14:0] HEAT_GAIN   = 15'((323996 * ONE_Q + 500000) / 1000000);
    localparam logic [18:0] VAL_CAP     = 19'(4 * ONE_Q);
    localparam logic [13:0] HEAT_SPAN   = 14'd9216;

    localparam logic [2:0] CFG_MIN_X   = 3'd0;
    localparam logic [2:0] CFG_MIN_Y   = 3'd1;
    localparam logic [2:0] CFG_MIN_Z   = 3'd2;
    localparam logic [2:0] CFG_SCALE   = 3'd3;
    localparam logic [2:0] CFG_ORG_X   = 3'd4;
    localparam logic [2:0] CFG_ORG_Y   = 3'd5;
    localparam logic [2:0] CFG_ORG_Z   = 3'd6;
    localparam logic [2:0] CFG_INV_MAX = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
    } t_side;

endpackage

/* rtl/point_normalize_distance_colour.sv */
`timescale 1ns / 1ps
// normalizes each point (subtract min corner, times common scale, saturate) and colors it
// by its distance from the origin through a six-segment heat map; one point enters per
// cycle while the output is not stalled; the pipeline depth is set mostly by the 34-step
// bit-per-stage square root; a stall on the output freezes the whole pipeline, so o_stall
// follows i_stall only while the output register holds a result; inv_max_distance of zero
// passes the input color through; config writes belong in idle periods
module point_normalize_distance_colour (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_x_in,
    input  logic [31:0] i_y_in,
    input  logic [31:0] i_z_in,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_x_out,
    output logic [31:0] o_y_out,
    output logic [31:0] o_z_out,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);

    localparam int NS = pndc_pkg::SQ_STEPS;

    // configuration registers
    logic [31:0] r_min [3];
    logic [31:0] r_org [3];
    logic [31:0] r_scale;
    logic [31:0] r_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min[0] <= '0;
            r_min[1] <= '0;
            r_min[2] <= '0;
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_scale  <= 32'(pndc_pkg::ONE_Q);
            r_inv    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pndc_pkg::CFG_MIN_X:   r_min[0] <= i_cfg_data;
                pndc_pkg::CFG_MIN_Y:   r_min[1] <= i_cfg_data;
                pndc_pkg::CFG_MIN_Z:   r_min[2] <= i_cfg_data;
                pndc_pkg::CFG_SCALE:   r_scale  <= i_cfg_data;
                pndc_pkg::CFG_ORG_X:   r_org[0] <= i_cfg_data;
                pndc_pkg::CFG_ORG_Y:   r_org[1] <= i_cfg_data;
                pndc_pkg::CFG_ORG_Z:   r_org[2] <= i_cfg_data;
                pndc_pkg::CFG_INV_MAX: r_inv    <= i_cfg_data;
            endcase
        end
    end

    // global advance: everything moves unless a finished result is held back
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // stage 1: difference from min corner, magnitude and sign
    logic        r1_v;
    logic [32:0] r1_mag [3];
    logic [2:0]  r1_neg;
    logic [23:0] r1_rgb;
    logic [31:0] pin [3];
    logic [32:0] n1_d [3];

    assign pin[0] = i_x_in;
    assign pin[1] = i_y_in;
    assign pin[2] = i_z_in;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n1_d[a] = {pin[a][31], pin[a]} - {r_min[a][31], r_min[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r1_neg[a] <= n1_d[a][32];
                r1_mag[a] <= n1_d[a][32] ? (~n1_d[a] + 33'd1) : n1_d[a];
            end
            r1_rgb <= {i_red_in, i_green_in, i_blue_in};
        end
    end

    // stage 2: scale multiply
    logic        r2_v;
    logic [64:0] r2_prod [3];
    logic [2:0]  r2_neg;
    logic [23:0] r2_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r2_prod[a] <= 65'(r1_mag[a] * r_scale);
            end
            r2_neg <= r1_neg;
            r2_rgb <= r1_rgb;
        end
    end

    // stage 3: drop fraction, saturate, restore sign
    logic        r3_v;
    pndc_pkg::t_side r3_side;
    logic [31:0] n3_lim [3];
    logic [31:0] n3_q   [3];
    logic [31:0] n3_n   [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n3_lim[a] = r2_neg[a] ? 32'h8000_0000 : 32'h7fff_ffff;
            n3_q[a]   = (r2_prod[a][64:16] > {17'd0, n3_lim[a]}) ? n3_lim[a]
                                                                 : r2_prod[a][47:16];
            n3_n[a]   = r2_neg[a] ? (~n3_q[a] + 32'd1) : n3_q[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_side.x <= n3_n[0];
            r3_side.y <= n3_n[1];
            r3_side.z <= n3_n[2];
            r3_side.r <= r2_rgb[23:16];
            r3_side.g <= r2_rgb[15:8];
            r3_side.b <= r2_rgb[7:0];
        end
    end

    // stage 4: offset from origin, magnitude
    logic        r4_v;
    logic [32:0] r4_e [3];
    pndc_pkg::t_side r4_side;
    logic [31:0] n4_p [3];
    logic [32:0] n4_d [3];

    assign n4_p[0] = r3_side.x;
    assign n4_p[1] = r3_side.y;
    assign n4_p[2] = r3_side.z;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n4_d[a] = {n4_p[a][31], n4_p[a]} - {r_org[a][31], r_org[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r4_e[a] <= n4_d[a][32] ? (~n4_d[a] + 33'd1) : n4_d[a];
            end
            r4_side <= r3_side;
        end
    end

    // stage 5: squares
    logic        r5_v;
    logic [65:0] r5_sq [3];
    pndc_pkg::t_side r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r5_sq[a] <= 66'(r4_e[a] * r4_e[a]);
            end
            r5_side <= r4_side;
        end
    end

    // stage 6: sum of squares
    logic        r6_v;
    logic [67:0] r6_sum;
    pndc_pkg::t_side r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_sum  <= {2'b00, r5_sq[0]} + {2'b00, r5_sq[1]} + {2'b00, r5_sq[2]};
            r6_side <= r5_side;
        end
    end

    // square root, one result bit per stage, remainder form
    logic            r_sq_v    [NS];
    logic [67:0]     r_sq_rad  [NS];
    logic [35:0]     r_sq_rem  [NS];
    logic [33:0]     r_sq_root [NS];
    pndc_pkg::t_side r_sq_side [NS];

    for (genvar k = 0; k < NS; k++) begin : g_sqrt
        logic            in_v;
        logic [67:0]     in_rad;
        logic [35:0]     in_rem;
        logic [33:0]     in_root;
        pndc_pkg::t_side in_side;
        logic [37:0]     rem_sh;
        logic [37:0]     trial;
        logic            take;

        if (k == 0) begin : g_first
            assign in_v    = r6_v;
            assign in_rad  = r6_sum;
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_side = r6_side;
        end else begin : g_next
            assign in_v    = r_sq_v[k-1];
            assign in_rad  = r_sq_rad[k-1];
            assign in_rem  = r_sq_rem[k-1];
            assign in_root = r_sq_root[k-1];
            assign in_side = r_sq_side[k-1];
        end

        assign rem_sh = {in_rem, in_rad[67:66]};
        assign trial  = {2'b00, in_root, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (en) begin
                r_sq_v[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rad[k]  <= {in_rad[65:0], 2'b00};
                r_sq_rem[k]  <= take ? 36'(rem_sh - trial) : rem_sh[35:0];
                r_sq_root[k] <= {in_root[32:0], take};
                r_sq_side[k] <= in_side;
            end
        end
    end

    // distance times reciprocal of max distance
    logic        r7_v;
    logic [65:0] r7_prod;
    pndc_pkg::t_side r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r_sq_v[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_prod <= 66'(r_sq_root[NS-1] * r_inv);
            r7_side <= r_sq_side[NS-1];
        end
    end

    // val, capped at 4.0
    logic        r8_v;
    logic [18:0] r8_val;
    pndc_pkg::t_side r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_val  <= (r7_prod[65:16] > {31'd0, pndc_pkg::VAL_CAP}) ? pndc_pkg::VAL_CAP
                                                                     : r7_prod[34:16];
            r8_side <= r7_side;
        end
    end

    // t = offset + gain * val
    logic        r9_v;
    logic [17:0] r9_t;
    pndc_pkg::t_side r9_side;
    logic [33:0] n9_gv;

    assign n9_gv = 34'(pndc_pkg::HEAT_GAIN * r8_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_t    <= pndc_pkg::HEAT_OFFSET + n9_gv[33:16];
            r9_side <= r8_side;
        end
    end

    // t squared
    logic        r10_v;
    logic [17:0] r10_t;
    logic [19:0] r10_t2;
    pndc_pkg::t_side r10_side;
    logic [35:0] n10_p;

    assign n10_p = 36'(r9_t * r9_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else if (en) begin
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_t    <= r9_t;
            r10_t2   <= n10_p[35:16];
            r10_side <= r9_side;
        end
    end

    // t cubed
    logic        r11_v;
    logic [21:0] r11_t3;
    pndc_pkg::t_side r11_side;
    logic [37:0] n11_p;

    assign n11_p = 38'(r10_t2 * r10_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else if (en) begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_t3   <= n11_p[37:16];
            r11_side <= r10_side;
        end
    end

    // palette position
    logic        r12_v;
    logic [19:0] r12_pval;
    pndc_pkg::t_side r12_side;
    logic [35:0] n12_p;

    assign n12_p = 36'(r11_t3 * pndc_pkg::HEAT_SPAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_v <= 1'b0;
        end else if (en) begin
            r12_v <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_pval <= n12_p[35:16];
            r12_side <= r11_side;
        end
    end

    // palette lookup and output register
    logic        r_out_v;
    pndc_pkg::t_side r_out;
    logic [7:0]  lb;
    logic [7:0]  n_r;
    logic [7:0]  n_g;
    logic [7:0]  n_b;

    assign lb = r12_pval[7:0];

    always_comb begin
        unique case (r12_pval[19:8])
            12'd0: begin n_r = 8'd255;       n_g = 8'd255 - lb; n_b = 8'd255 - lb; end
            12'd1: begin n_r = 8'd255;       n_g = lb;          n_b = 8'd0;        end
            12'd2: begin n_r = 8'd255 - lb;  n_g = 8'd255;      n_b = 8'd0;        end
            12'd3: begin n_r = 8'd0;         n_g = 8'd255;      n_b = lb;          end
            12'd4: begin n_r = 8'd0;         n_g = 8'd255 - lb; n_b = 8'd255;      end
            12'd5: begin n_r = 8'd0;         n_g = 8'd0;        n_b = 8'd255 - lb; end
            default: begin n_r = 8'd0;       n_g = 8'd0;        n_b = 8'd0;        end
        endcase
        // coloring off: keep input color
        if (r_inv == 32'd0) begin
            n_r = r12_side.r;
            n_g = r12_side.g;
            n_b = r12_side.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.x <= r12_side.x;
            r_out.y <= r12_side.y;
            r_out.z <= r12_side.z;
            r_out.r <= n_r;
            r_out.g <= n_g;
            r_out.b <= n_b;
        end
    end

    assign o_valid     = r_out_v;
    assign o_x_out     = r_out.x;
    assign o_y_out     = r_out.y;
    assign o_z_out     = r_out.z;
    assign o_red_out   = r_out.r;
    assign o_green_out = r_out.g;
    assign o_blue_out  = r_out.b;

endmodule
